/* rtl/tmwf_pkg.sv */
// ----------------------------------------------------------------------------
// tmwf_pkg: shared types and constants of the trimmed-mean window filter
// Sequencer states, divider status, the configuration width and window constants.
// ----------------------------------------------------------------------------
package tmwf_pkg;

    // width of the window_width configuration register
    localparam int CFG_BITS   = 5;
    // window_width after reset
    localparam int CFG_RESET  = 8;
    // smallest usable window
    localparam int MIN_WIDTH  = 3;
    // entries dropped from the sum: the largest and the smallest
    localparam int TRIM_COUNT = 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_ROT,
        S_TRIM,
        S_PREP,
        S_LAUNCH,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
        logic neg;
    } t_div_stat;

endpackage

/* rtl/tmwf_cell.sv */
// ----------------------------------------------------------------------------
// tmwf_cell: one window entry of the sample chain
// Holds one sample and takes its neighbor's sample on every shift.
// ----------------------------------------------------------------------------
module tmwf_cell #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_shift,
    input  logic [SAMPLE_BITS-1:0] i_data,
    output logic [SAMPLE_BITS-1:0] o_data
);

    logic [SAMPLE_BITS-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

/* rtl/tmwf_div.sv */
// ----------------------------------------------------------------------------
// tmwf_div: serial signed-by-unsigned divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module tmwf_div #(
    parameter int NUM_BITS = 31,
    parameter int DEN_BITS = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [NUM_BITS-1:0]  i_num,
    input  logic        [DEN_BITS-1:0]  i_den,
    output tmwf_pkg::t_div_stat         o_stat,
    output logic        [NUM_BITS-1:0]  o_quot
);
    import tmwf_pkg::*;

    localparam int CNT_BITS = $clog2(NUM_BITS);
    localparam logic [CNT_BITS-1:0] LAST_CNT = CNT_BITS'(NUM_BITS - 1);

    logic                r_busy;
    logic                r_done;
    logic                r_neg;
    logic [CNT_BITS-1:0] r_cnt;
    logic [NUM_BITS-1:0] r_q;
    logic [DEN_BITS-1:0] r_rem;

    logic [NUM_BITS-1:0] num_mag;
    logic [DEN_BITS:0]   rem_sh;
    logic [DEN_BITS:0]   rem_diff;
    logic                q_bit;
    logic [DEN_BITS-1:0] n_rem;

    always_comb begin
        num_mag  = i_num[NUM_BITS-1] ? NUM_BITS'(-i_num) : NUM_BITS'(i_num);
        rem_sh   = {r_rem, r_q[NUM_BITS-1]};
        rem_diff = rem_sh - {1'b0, i_den};
        q_bit    = (rem_sh >= {1'b0, i_den});
        n_rem    = q_bit ? rem_diff[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_CNT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift the dividend out at the top, the quotient in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= num_mag;
            r_rem <= '0;
            r_neg <= i_num[NUM_BITS-1];
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_BITS-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.neg  = r_neg;
    assign o_quot      = r_q;

endmodule

/* rtl/trimmed_mean_window_filter.sv */
// ----------------------------------------------------------------------------
// trimmed_mean_window_filter: moving trimmed mean over a ring of samples
// Keeps the last W samples and outputs their mean without the extremes (the sample itself on restart).
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one item: a signed
//   sample and a restart flag. Output channel (o_out_valid / i_out_ready)
//   returns one filtered value per item, in order.
//   i_cfg_we / i_cfg_data write the window width W; values below 3 act as 3,
//   values above MAX_WIDTH act as MAX_WIDTH. Write only while idle.
// Sequence
//   One item at a time. After acceptance: the write position is checked and,
//   if a lowered width left it stale, reduced by W (at most (MAX_WIDTH-1)/3
//   reductions); the chain is rotated once through all MAX_WIDTH entries;
//   then trim, prep and launch, a serial divide of a NUM_BITS-bit numerator
//   (NUM_BITS = SAMPLE_BITS + clog2(MAX_WIDTH) + 3) and the output load, after
//   which the sequencer is idle again. On restart trim and divide are skipped.
// Reset
//   Clears every window entry to zero, the write position to zero and the
//   width register to 8.
// Stall
//   The result sits in an output register; a new item is taken while it
//   waits. A second result waits in the sequencer until the first is taken.
// ----------------------------------------------------------------------------
module trimmed_mean_window_filter #(
    parameter int MAX_WIDTH   = 16,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tmwf_pkg::CFG_BITS-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  logic                              i_restart,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]     o_filtered
);
    import tmwf_pkg::*;

    localparam int IW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int EW   = (CFG_BITS > WW) ? CFG_BITS : WW;
    localparam int SUMW = SAMPLE_BITS + $clog2(MAX_WIDTH) + 1;
    localparam int NW   = SUMW + 2;
    localparam int DW   = EW + 1;
    localparam logic [IW-1:0] LAST_K = IW'(MAX_WIDTH - 1);

    t_state                   r_state;
    t_state                   n_state;
    logic [CFG_BITS-1:0]      r_width;
    logic [IW-1:0]            r_k;
    logic [IW-1:0]            r_wpos;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                     r_restart;
    logic signed [SUMW-1:0]   r_sum;
    logic signed [SAMPLE_BITS-1:0] r_hi;
    logic signed [SAMPLE_BITS-1:0] r_lo;
    logic signed [NW-1:0]     r_num;
    logic signed [SAMPLE_BITS-1:0] r_res;
    logic                     r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out;

    logic [EW-1:0]            cfg_ext;
    logic [EW-1:0]            w_eff;
    logic [EW-1:0]            d_val;
    logic [EW-1:0]            pos_ext;
    logic [EW-1:0]            pos_sub;
    logic [EW-1:0]            pos_inc;
    logic                     in_win;
    logic                     wr_hit;
    logic                     chain_shift;
    logic                     in_acc;
    logic                     out_free;
    logic [SAMPLE_BITS-1:0]   chain [MAX_WIDTH];
    logic signed [SAMPLE_BITS-1:0] head;
    logic signed [SAMPLE_BITS-1:0] head_new;
    logic [DW-1:0]            div_den;
    logic                     div_start;
    t_div_stat                div_stat;
    logic [NW-1:0]            div_quot;
    logic [SAMPLE_BITS-1:0]   quot_lo;

    // effective window width and divisor
    always_comb begin
        cfg_ext = EW'(r_width);
        if (cfg_ext > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else if (cfg_ext < EW'(MIN_WIDTH)) begin
            w_eff = EW'(MIN_WIDTH);
        end else begin
            w_eff = cfg_ext;
        end
        d_val   = w_eff - EW'(TRIM_COUNT);
        div_den = {d_val, 1'b0};
    end

    always_comb begin
        pos_ext  = EW'(r_wpos);
        pos_sub  = pos_ext - w_eff;
        pos_inc  = pos_ext + 1'b1;
        in_win   = EW'(r_k) < w_eff;
        wr_hit   = (r_k == r_wpos) || (r_restart && in_win);
        head     = chain[0];
        head_new = wr_hit ? r_sample : head;
        in_acc   = i_in_valid && o_in_ready;
        out_free = !r_out_valid || i_out_ready;
        chain_shift = (r_state == S_ROT);
        div_start   = (r_state == S_LAUNCH);
        quot_lo     = div_quot[SAMPLE_BITS-1:0];
    end

    // chain of window cells: rotate by one entry per cycle in S_ROT, head (or the new sample) fed back to tail
    for (genvar g = 0; g < MAX_WIDTH; g++) begin : g_cell
        logic [SAMPLE_BITS-1:0] cell_in;
        if (g == MAX_WIDTH - 1) begin : g_tail
            assign cell_in = head_new;
        end else begin : g_body
            assign cell_in = chain[g+1];
        end
        tmwf_cell #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_shift(chain_shift),
            .i_data (cell_in),
            .o_data (chain[g])
        );
    end

    tmwf_div #(
        .NUM_BITS(NW),
        .DEN_BITS(DW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (r_num),
        .i_den  (div_den),
        .o_stat (div_stat),
        .o_quot (div_quot)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_acc) n_state = S_MOD;
            S_MOD:    if (pos_ext < w_eff) n_state = S_ROT;
            S_ROT: begin
                if (r_k == LAST_K) begin
                    n_state = r_restart ? S_OUT : S_TRIM;
                end
            end
            S_TRIM:   n_state = S_PREP;
            S_PREP:   n_state = S_LAUNCH;
            S_LAUNCH: n_state = S_DIV;
            S_DIV:    if (div_stat.done) n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= CFG_BITS'(CFG_RESET);
            r_wpos      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_width <= i_cfg_data;
            end
            // reduce a write position left stale by a narrower window
            if (r_state == S_MOD && pos_ext >= w_eff) begin
                r_wpos <= pos_sub[IW-1:0];
            end
            if (r_state == S_ROT) begin
                if (r_k == LAST_K) begin
                    r_k    <= '0;
                    r_wpos <= (pos_inc == w_eff) ? '0 : pos_inc[IW-1:0];
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample  <= i_sample;
            r_restart <= i_restart;
            r_sum     <= '0;
            r_hi      <= i_sample;
            r_lo      <= i_sample;
        end
        // accumulate the entries inside the window as they pass the head
        if (r_state == S_ROT && in_win) begin
            r_sum <= r_sum + SUMW'(head_new);
            if (head_new > r_hi) begin
                r_hi <= head_new;
            end
            if (head_new < r_lo) begin
                r_lo <= head_new;
            end
        end
        if (r_state == S_ROT && r_k == LAST_K && r_restart) begin
            r_res <= r_sample;
        end
        // drop the extremes
        if (r_state == S_TRIM) begin
            r_sum <= r_sum - SUMW'(r_hi) - SUMW'(r_lo);
        end
        // add half the divisor for rounding
        if (r_state == S_PREP) begin
            r_num <= (NW'(r_sum) <<< 1) + signed'(NW'(d_val));
        end
        if (r_state == S_DIV && div_stat.done) begin
            r_res <= div_stat.neg ? signed'(-quot_lo) : signed'(quot_lo);
        end
        if (r_state == S_OUT && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_out;

`ifndef SYNTHESIS
    a_wpos_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT && r_k == LAST_K) |=> (EW'(r_wpos) < $past(w_eff)))
        else $error("write position outside window after rotation");

    a_div_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAUNCH) |-> !div_stat.busy)
        else $error("divider started while busy");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_MOD))
        else $error("accepted item did not start processing");

    a_k_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ROT) |-> (r_k == '0))
        else $error("entry counter not cleared outside rotation");
`endif

endmodule
